// ===== rtl/hfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package hfd_pkg;

  // Request kinds as they arrive on req_type
  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_LOAD   = 2'd1,
    REQ_BIT    = 2'd2,
    REQ_REPEAT = 2'd3
  } hfd_req_e;

  // Result status codes
  localparam logic [2:0] ST_SYMBOL   = 3'd0;
  localparam logic [2:0] ST_LOAD_OK  = 3'd1;
  localparam logic [2:0] ST_LOAD_ERR = 3'd2;
  localparam logic [2:0] ST_BAD_PATH = 3'd3;
  localparam logic [2:0] ST_DONE     = 3'd4;

  // Loaded symbol count saturates here
  localparam logic [8:0] LOADED_SAT = 9'd511;

  // One classified beat as it sits in the queue
  typedef struct packed {
    hfd_req_e    kind;
    logic        bad_len;
    logic [7:0]  sym;
    logic [5:0]  len;
    logic [31:0] bits;
    logic        bit_val;
  } hfd_item_t;

endpackage
`default_nettype wire

// ===== rtl/hfd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one word, read one word registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/hfd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hfd_front #(
  parameter int MAX_CODE_LEN = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        req_type_i,
  input  wire logic [7:0]        symbol_i,
  input  wire logic [5:0]        code_length_i,
  input  wire logic [31:0]       code_bits_i,
  input  wire logic              stream_bit_i,
  output logic                   head_valid_o,
  output hfd_pkg::hfd_item_t     head_o,
  input  wire logic              pop_i
);
  import hfd_pkg::*;

  hfd_item_t  slot_q [2];
  hfd_item_t  item;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;

  // Classify the incoming beat
  always_comb begin
    item.kind    = hfd_req_e'(req_type_i);
    item.bad_len = (code_length_i == 6'd0) ||
                   ({1'b0, code_length_i} > 7'(MAX_CODE_LEN));
    item.sym     = symbol_i;
    item.len     = code_length_i;
    item.bits    = code_bits_i;
    item.bit_val = stream_bit_i;
  end

  assign in_stall_o   = (cnt_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = slot_q[rd_ptr_q];

  // Advance queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop_i) rd_ptr_q <= !rd_ptr_q;
      if (push && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (!push && pop_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  // Hold queued beats
  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= item;
  end

endmodule
`default_nettype wire

// ===== rtl/hfd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hfd_back #(
  parameter int NODE_COUNT = 512
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [31:0]       cfg_data_i,
  input  wire logic              head_valid_i,
  input  wire hfd_pkg::hfd_item_t head_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [2:0]             status_o,
  output logic [7:0]             symbol_out_o,
  output logic                   last_o
);
  import hfd_pkg::*;

  localparam int NW = $clog2(NODE_COUNT);
  localparam int EW = 9 + 2 * NW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LGOT  = 3'd1;
  localparam logic [2:0] S_LSTEP = 3'd2;
  localparam logic [2:0] S_LPAR  = 3'd3;
  localparam logic [2:0] S_BCHK  = 3'd4;
  localparam logic [2:0] S_BLEAF = 3'd5;

  typedef struct packed {
    logic          leaf;
    logic [7:0]    sym;
    logic [NW-1:0] c1;
    logic [NW-1:0] c0;
  } node_t;

  logic [2:0]    state_q, state_d;
  hfd_item_t     itm_q, itm_d;
  node_t         ent_q, ent_d, rd_ent, wr_ent;
  logic [NW-1:0] at_q, at_d, cur_q, cur_d, nxt_q, nxt_d;
  logic [NW:0]   nfree_q, nfree_d;
  logic [5:0]    i_q, i_d;
  logic [31:0]   emitted_q, emitted_d, total_q;
  logic [8:0]    loaded_q, loaded_d;
  logic [7:0]    only_q, only_d;
  logic          root_ok_q, root_ok_d, rd_zero_q;
  logic          out_valid_q, out_valid_d, last_q, last_d;
  logic [2:0]    status_q, status_d;
  logic [7:0]    sym_out_q, sym_out_d;

  logic          we;
  logic [NW-1:0] waddr, raddr;
  logic [EW-1:0] rdata;
  logic          out_free, full, dir, last_step;
  logic [NW-1:0] step_child, bit_child;
  logic [31:0]   emitted_inc;

  hfd_ram #(.WIDTH(EW), .DEPTH(NODE_COUNT)) u_nodes (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (EW'(wr_ent)),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Root reads as an empty node until first written
  assign rd_ent      = (rd_zero_q && !root_ok_q) ? '0 : node_t'(rdata);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign full        = (nfree_q >= (NW+1)'(NODE_COUNT));
  assign dir         = (i_q[5] == 1'b0) ? itm_q.bits[i_q[4:0]] : 1'b0;
  assign last_step   = (i_q == itm_q.len - 6'd1);
  assign step_child  = dir ? ent_q.c1 : ent_q.c0;
  assign bit_child   = itm_q.bit_val ? rd_ent.c1 : rd_ent.c0;
  assign emitted_inc = emitted_q + 32'd1;

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign symbol_out_o = sym_out_q;
  assign last_o       = last_q;

  always_comb begin
    state_d     = state_q;
    itm_d       = itm_q;
    ent_d       = ent_q;
    at_d        = at_q;
    cur_d       = cur_q;
    nxt_d       = nxt_q;
    nfree_d     = nfree_q;
    i_d         = i_q;
    emitted_d   = emitted_q;
    loaded_d    = loaded_q;
    only_d      = only_q;
    root_ok_d   = root_ok_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    sym_out_d   = sym_out_q;
    last_d      = last_q;
    pop_o       = 1'b0;
    we          = 1'b0;
    waddr       = at_q;
    wr_ent      = '0;
    raddr       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (head_valid_i && out_free) begin
          pop_o = 1'b1;
          itm_d = head_i;
          unique case (head_i.kind)
            REQ_CLEAR: begin
              we        = 1'b1;
              waddr     = '0;
              root_ok_d = 1'b1;
              cur_d     = '0;
              nfree_d   = (NW+1)'(1);
              emitted_d = '0;
              loaded_d  = '0;
              only_d    = '0;
            end
            REQ_LOAD: begin
              if (head_i.bad_len) begin
                out_valid_d = 1'b1;
                status_d    = ST_LOAD_ERR;
                sym_out_d   = '0;
                last_d      = 1'b0;
              end else begin
                raddr   = '0;
                at_d    = '0;
                i_d     = '0;
                state_d = S_LGOT;
              end
            end
            default: begin
              out_valid_d = 1'b1;
              sym_out_d   = '0;
              last_d      = 1'b0;
              if (emitted_q >= total_q) begin
                status_d = ST_DONE;
              end else if (head_i.kind == REQ_REPEAT) begin
                if (loaded_q != 9'd1) begin
                  status_d = ST_BAD_PATH;
                end else begin
                  status_d  = ST_SYMBOL;
                  sym_out_d = only_q;
                  last_d    = (emitted_inc == total_q);
                  emitted_d = emitted_inc;
                end
              end else begin
                // Walk one bit: read the current node first
                out_valid_d = 1'b0;
                raddr       = cur_q;
                state_d     = S_BCHK;
              end
            end
          endcase
        end
      end

      S_LGOT: begin
        if (rd_ent.leaf) begin
          out_valid_d = 1'b1;
          status_d    = ST_LOAD_ERR;
          sym_out_d   = '0;
          last_d      = 1'b0;
          state_d     = S_IDLE;
        end else begin
          ent_d   = rd_ent;
          state_d = S_LSTEP;
        end
      end

      S_LSTEP: begin
        if (!last_step && step_child != '0) begin
          // Descend into an existing inner node
          raddr   = step_child;
          at_d    = step_child;
          i_d     = i_q + 6'd1;
          state_d = S_LGOT;
        end else if ((last_step && step_child != '0) || full) begin
          out_valid_d = 1'b1;
          status_d    = ST_LOAD_ERR;
          sym_out_d   = '0;
          last_d      = 1'b0;
          state_d     = S_IDLE;
        end else begin
          // Create the new node, parent link follows
          we     = 1'b1;
          waddr  = nfree_q[NW-1:0];
          wr_ent = '0;
          if (last_step) begin
            wr_ent.leaf = 1'b1;
            wr_ent.sym  = itm_q.sym;
          end
          state_d = S_LPAR;
        end
      end

      S_LPAR: begin
        we     = 1'b1;
        waddr  = at_q;
        wr_ent = ent_q;
        if (dir) wr_ent.c1 = nfree_q[NW-1:0];
        else wr_ent.c0 = nfree_q[NW-1:0];
        if (at_q == '0) root_ok_d = 1'b1;
        nfree_d = nfree_q + (NW+1)'(1);
        if (last_step) begin
          if (loaded_q < LOADED_SAT) loaded_d = loaded_q + 9'd1;
          only_d      = itm_q.sym;
          out_valid_d = 1'b1;
          status_d    = ST_LOAD_OK;
          sym_out_d   = '0;
          last_d      = 1'b0;
          state_d     = S_IDLE;
        end else begin
          at_d    = nfree_q[NW-1:0];
          ent_d   = '0;
          i_d     = i_q + 6'd1;
          state_d = S_LSTEP;
        end
      end

      S_BCHK: begin
        if (bit_child == '0 || {1'b0, bit_child} >= (NW+1)'(NODE_COUNT)) begin
          cur_d       = '0;
          out_valid_d = 1'b1;
          status_d    = ST_BAD_PATH;
          sym_out_d   = '0;
          last_d      = 1'b0;
          state_d     = S_IDLE;
        end else begin
          raddr   = bit_child;
          nxt_d   = bit_child;
          state_d = S_BLEAF;
        end
      end

      S_BLEAF: begin
        if (rd_ent.leaf) begin
          cur_d       = '0;
          out_valid_d = 1'b1;
          status_d    = ST_SYMBOL;
          sym_out_d   = rd_ent.sym;
          last_d      = (emitted_inc == total_q);
          emitted_d   = emitted_inc;
        end else begin
          cur_d = nxt_q;
        end
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= '0;
      nfree_q     <= (NW+1)'(1);
      emitted_q   <= '0;
      loaded_q    <= '0;
      only_q      <= '0;
      root_ok_q   <= 1'b0;
      rd_zero_q   <= 1'b0;
      out_valid_q <= 1'b0;
      total_q     <= '0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      nfree_q     <= nfree_d;
      emitted_q   <= emitted_d;
      loaded_q    <= loaded_d;
      only_q      <= only_d;
      root_ok_q   <= root_ok_d;
      rd_zero_q   <= (raddr == '0);
      out_valid_q <= out_valid_d;
      if (cfg_we_i) total_q <= cfg_data_i;
    end
  end

  // Working payload
  always_ff @(posedge clk_i) begin
    itm_q     <= itm_d;
    ent_q     <= ent_d;
    at_q      <= at_d;
    nxt_q     <= nxt_d;
    i_q       <= i_d;
    status_q  <= status_d;
    sym_out_q <= sym_out_d;
    last_q    <= last_d;
  end

endmodule
`default_nettype wire

// ===== rtl/huffman_tree_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Handshake              Payload
// cfg      in         cfg_we_i               cfg_data_i (symbol total)
// in       in         in_valid_i/in_stall_o  req_type, symbol, code_length, code_bits, stream_bit
// out      out        out_valid_o/out_stall_i status, symbol_out, last
//
// A bit beat passes in order through node read, child read and leaf check in the back end,
// as the node memory read is registered. Clear, repeat and done beats are handled in idle.
// A load reads and steps each existing level, and writes each created node then its parent link.
// A two-beat queue lets the input run ahead while a result waits on out_stall_i.
// Reset empties the tree at once; no clearing pass over the node memory.
module huffman_tree_decoder #(
  parameter int MAX_CODE_LEN = 32,
  parameter int NODE_COUNT   = 512
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [7:0]  symbol_i,
  input  wire logic [5:0]  code_length_i,
  input  wire logic [31:0] code_bits_i,
  input  wire logic        stream_bit_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [7:0]       symbol_out_o,
  output logic             last_o
);
  import hfd_pkg::*;

  hfd_item_t head;
  logic      head_valid, pop;

  hfd_front #(.MAX_CODE_LEN(MAX_CODE_LEN)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .symbol_i      (symbol_i),
    .code_length_i (code_length_i),
    .code_bits_i   (code_bits_i),
    .stream_bit_i  (stream_bit_i),
    .head_valid_o  (head_valid),
    .head_o        (head),
    .pop_i         (pop)
  );

  hfd_back #(.NODE_COUNT(NODE_COUNT)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .symbol_out_o (symbol_out_o),
    .last_o       (last_o)
  );

endmodule
`default_nettype wire
